/* sv/fnu_pkg.sv */
// Shared types and fixed widths for the face normal unit.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package fnu_pkg;

    localparam int NORM_BITS = 31;
    localparam int SQ_BITS   = 2 * NORM_BITS;
    localparam int SUM_BITS  = 64;
    localparam int ROOT_BITS = 32;
    localparam int OUT_BITS  = 16;
    localparam int OUT_MAX   = 32767;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
        logic       last;
    } side_t;

    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] mag;
        side_t                     side;
    } norm_t;

endpackage

/* sv/fnu_front.sv */
// Edge vectors, optional edge prescale and cross product, four stages.
// Depends on fnu_pkg.
`timescale 1ns / 1ps

module fnu_front import fnu_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int MAG_BITS   = 36
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] p [9],
    input  logic                         last_in,
    output logic                         out_valid,
    output logic [MAG_BITS-1:0]          mag [3],
    output side_t                        side
);

    localparam int EW  = COORD_BITS + 1;
    localparam int EMW = (EW > 30) ? 30 : EW;
    localparam int ESH = EW - EMW;
    localparam int ESW = EMW + 1;
    localparam int PW  = MAG_BITS;

    logic [3:0] v_reg;
    logic [3:0] last_reg;

    logic signed [EW-1:0]  ed_reg  [6];
    logic signed [EW-1:0]  ed_next [6];
    logic signed [ESW-1:0] es_reg  [6];
    logic signed [ESW-1:0] es_next [6];
    logic signed [PW-1:0]  pr_reg  [6];
    logic signed [PW-1:0]  pr_next [6];
    logic [PW-1:0]         mag_reg  [3];
    logic [PW-1:0]         mag_next [3];
    logic [2:0]            neg_reg;
    logic [2:0]            neg_next;
    logic                  degen_reg;
    logic                  zero_next;

    // Edges, then magnitudes scaled so that every edge stays below 2^30.
    always_comb
    begin
        logic [EW-1:0]  emag [6];
        logic [5:0]     eneg;
        logic [EW-1:0]  orv;
        logic [2:0]     sh;
        logic           found;
        logic [EMW-1:0] sm;
        logic signed [ESW-1:0] sv;
        for (int j = 0; j < 3; j++)
        begin
            ed_next[j]     = EW'(p[3+j]) - EW'(p[j]);
            ed_next[3+j]   = EW'(p[6+j]) - EW'(p[j]);
        end
        orv = '0;
        for (int k = 0; k < 6; k++)
        begin
            eneg[k] = ed_reg[k][EW-1];
            emag[k] = eneg[k] ? EW'(-ed_reg[k]) : EW'(ed_reg[k]);
            orv     = orv | emag[k];
        end
        sh    = '0;
        found = 1'b0;
        for (int k = 0; k <= ESH; k++)
        begin
            if (!found && ((64'(orv) >> k) < 64'h4000_0000))
            begin
                sh    = 3'(k);
                found = 1'b1;
            end
        end
        for (int k = 0; k < 6; k++)
        begin
            sm = EMW'(emag[k] >> sh);
            sv = $signed({1'b0, sm});
            es_next[k] = eneg[k] ? -sv : sv;
        end
        pr_next[0] = PW'(es_reg[1]) * PW'(es_reg[5]);
        pr_next[1] = PW'(es_reg[2]) * PW'(es_reg[4]);
        pr_next[2] = PW'(es_reg[2]) * PW'(es_reg[3]);
        pr_next[3] = PW'(es_reg[0]) * PW'(es_reg[5]);
        pr_next[4] = PW'(es_reg[0]) * PW'(es_reg[4]);
        pr_next[5] = PW'(es_reg[1]) * PW'(es_reg[3]);
    end

    // Cross product components; magnitudes always fit PW bits.
    always_comb
    begin
        logic signed [PW:0] cx;
        zero_next = 1'b1;
        for (int j = 0; j < 3; j++)
        begin
            cx          = (PW+1)'(pr_reg[2*j]) - (PW+1)'(pr_reg[2*j+1]);
            neg_next[j] = cx[PW];
            mag_next[j] = cx[PW] ? PW'(-cx) : PW'(cx);
            if (mag_next[j] != '0)
            begin
                zero_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg  <= {last_reg[2:0], last_in};
            ed_reg    <= ed_next;
            es_reg    <= es_next;
            pr_reg    <= pr_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            degen_reg <= zero_next;
        end
    end

    assign out_valid  = v_reg[3];
    assign mag        = mag_reg;
    assign side.neg   = neg_reg;
    assign side.degen = degen_reg;
    assign side.last  = last_reg[3];

endmodule

/* sv/fnu_norm.sv */
// Scales the cross product so its largest component lies in [2^30, 2^31),
// then forms the sum of squares. Four stages. Depends on fnu_pkg.
`timescale 1ns / 1ps

module fnu_norm import fnu_pkg::*; #(
    parameter int MAG_BITS = 36
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [MAG_BITS-1:0] mag [3],
    input  side_t               side,
    output logic                out_valid,
    output logic [SUM_BITS-1:0] sum,
    output norm_t               nt
);

    localparam int LW = $clog2(MAG_BITS);
    localparam logic [LW-1:0] TOP = LW'(NORM_BITS - 1);

    logic [3:0]          v_reg;
    side_t               sd_reg [3];
    logic [MAG_BITS-1:0] m5_reg [3];
    logic [LW-1:0]       lead_reg;
    logic [LW-1:0]       lead_next;
    logic [NORM_BITS-1:0] nm_reg  [3];
    logic [NORM_BITS-1:0] nm_next [3];
    logic [NORM_BITS-1:0] n7_reg  [3];
    logic [SQ_BITS-1:0]  sq_reg  [3];
    logic [SQ_BITS-1:0]  sq_next [3];
    logic [SUM_BITS-1:0] sum_reg;
    norm_t               nt_reg;

    always_comb
    begin
        logic [MAG_BITS-1:0] orv;
        orv       = mag[0] | mag[1] | mag[2];
        lead_next = '0;
        for (int i = 0; i < MAG_BITS; i++)
        begin
            if (orv[i])
            begin
                lead_next = LW'(i);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            if (lead_reg >= TOP)
            begin
                nm_next[j] = NORM_BITS'(m5_reg[j] >> (lead_reg - TOP));
            end
            else
            begin
                nm_next[j] = NORM_BITS'(m5_reg[j]) << (TOP - lead_reg);
            end
            sq_next[j] = SQ_BITS'(nm_reg[j]) * SQ_BITS'(nm_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m5_reg   <= mag;
            lead_reg <= lead_next;
            sd_reg[0] <= side;
            sd_reg[1] <= sd_reg[0];
            sd_reg[2] <= sd_reg[1];
            nm_reg   <= nm_next;
            n7_reg   <= nm_reg;
            sq_reg   <= sq_next;
            sum_reg  <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1])
                        + SUM_BITS'(sq_reg[2]);
            for (int j = 0; j < 3; j++)
            begin
                nt_reg.mag[j] <= n7_reg[j];
            end
            nt_reg.side <= sd_reg[2];
        end
    end

    assign out_valid = v_reg[3];
    assign sum       = sum_reg;
    assign nt        = nt_reg;

endmodule

/* sv/fnu_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on fnu_pkg.
`timescale 1ns / 1ps

module fnu_sqrt import fnu_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [SUM_BITS-1:0]  sum,
    input  norm_t                in_nt,
    output logic                 out_valid,
    output logic [ROOT_BITS-1:0] root,
    output norm_t                out_nt
);

    localparam int RW = ROOT_BITS + 2;

    logic [ROOT_BITS-1:0] v_reg;
    logic [RW-1:0]        rem_reg   [ROOT_BITS];
    logic [RW-1:0]        rem_next  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_next [ROOT_BITS];
    logic [SUM_BITS-1:0]  s_reg     [ROOT_BITS];
    logic [SUM_BITS-1:0]  s_next    [ROOT_BITS];
    norm_t                nt_reg    [ROOT_BITS];

    // Each stage brings down two bits of the radicand and tries one root bit.
    always_comb
    begin
        logic [RW-1:0]        rin;
        logic [ROOT_BITS-1:0] qin;
        logic [SUM_BITS-1:0]  sin;
        logic [RW-1:0]        t;
        logic [RW-1:0]        trial;
        for (int k = 0; k < ROOT_BITS; k++)
        begin
            if (k == 0)
            begin
                rin = '0;
                qin = '0;
                sin = sum;
            end
            else
            begin
                rin = rem_reg[k-1];
                qin = root_reg[k-1];
                sin = s_reg[k-1];
            end
            t     = {rin[RW-3:0], sin[SUM_BITS-1 -: 2]};
            trial = {qin, 2'b01};
            if (t >= trial)
            begin
                rem_next[k]  = t - trial;
                root_next[k] = {qin[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = t;
                root_next[k] = {qin[ROOT_BITS-2:0], 1'b0};
            end
            s_next[k] = sin << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[ROOT_BITS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            s_reg    <= s_next;
            nt_reg[0] <= in_nt;
            for (int k = 1; k < ROOT_BITS; k++)
            begin
                nt_reg[k] <= nt_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[ROOT_BITS-1];
    assign root      = root_reg[ROOT_BITS-1];
    assign out_nt    = nt_reg[ROOT_BITS-1];

endmodule

/* sv/fnu_div.sv */
// Rounded division of each scaled component by the length, one quotient
// bit per stage, then clamp, sign and output register. Depends on fnu_pkg.
`timescale 1ns / 1ps

module fnu_div import fnu_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [ROOT_BITS-1:0] root,
    input  norm_t                in_nt,
    output logic                 out_valid,
    output logic [OUT_BITS-1:0]  nx,
    output logic [OUT_BITS-1:0]  ny,
    output logic [OUT_BITS-1:0]  nz,
    output logic                 degen,
    output logic                 last
);

    localparam int QB  = NORMAL_FRAC_BITS + 1;
    localparam int NW  = NORM_BITS + QB;
    localparam int RM  = ROOT_BITS + 1;
    localparam int LIM = ((1 << NORMAL_FRAC_BITS) > OUT_MAX) ? OUT_MAX
                         : (1 << NORMAL_FRAC_BITS);

    logic                 pv_reg;
    logic [RM-1:0]        prem_reg [3];
    logic [QB-1:0]        plo_reg  [3];
    logic [ROOT_BITS-1:0] pl_reg;
    side_t                psd_reg;

    logic [QB-1:0]        v_reg;
    logic [RM-1:0]        rem_reg  [QB][3];
    logic [RM-1:0]        rem_next [QB][3];
    logic [QB-1:0]        lo_reg   [QB][3];
    logic [QB-1:0]        lo_next  [QB][3];
    logic [QB-1:0]        q_reg    [QB][3];
    logic [QB-1:0]        q_next   [QB][3];
    logic [ROOT_BITS-1:0] l_reg    [QB];
    side_t                sd_reg   [QB];

    logic [RM-1:0]        prem_next [3];
    logic [QB-1:0]        plo_next  [3];
    logic [OUT_BITS-1:0]  o_next    [3];

    logic                 ov_reg;
    logic [OUT_BITS-1:0]  o_reg [3];
    logic                 degen_reg;
    logic                 last_reg;

    // Numerator is m * 2^F plus half the length; its top bits start the remainder.
    always_comb
    begin
        logic [NW-1:0] n;
        for (int j = 0; j < 3; j++)
        begin
            n = (NW'(in_nt.mag[j]) << NORMAL_FRAC_BITS) + NW'(root >> 1);
            prem_next[j] = RM'(n >> QB);
            plo_next[j]  = n[QB-1:0];
        end
    end

    always_comb
    begin
        logic [RM-1:0]        rin;
        logic [QB-1:0]        lin;
        logic [QB-1:0]        qin;
        logic [ROOT_BITS-1:0] dv;
        logic [RM-1:0]        t;
        for (int k = 0; k < QB; k++)
        begin
            dv = (k == 0) ? pl_reg : l_reg[k-1];
            for (int j = 0; j < 3; j++)
            begin
                if (k == 0)
                begin
                    rin = prem_reg[j];
                    lin = plo_reg[j];
                    qin = '0;
                end
                else
                begin
                    rin = rem_reg[k-1][j];
                    lin = lo_reg[k-1][j];
                    qin = q_reg[k-1][j];
                end
                t = {rin[RM-2:0], lin[QB-1]};
                if (t >= RM'(dv))
                begin
                    rem_next[k][j] = t - RM'(dv);
                    q_next[k][j]   = {qin[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][j] = t;
                    q_next[k][j]   = {qin[QB-2:0], 1'b0};
                end
                lo_next[k][j] = lin << 1;
            end
        end
    end

    always_comb
    begin
        logic [QB-1:0]       q;
        logic [OUT_BITS-1:0] qc;
        for (int j = 0; j < 3; j++)
        begin
            q  = q_reg[QB-1][j];
            qc = (q > QB'(LIM)) ? OUT_BITS'(LIM) : OUT_BITS'(q);
            if (sd_reg[QB-1].degen)
            begin
                o_next[j] = '0;
            end
            else
            begin
                o_next[j] = sd_reg[QB-1].neg[j] ? -qc : qc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            pv_reg <= in_valid;
            v_reg  <= {v_reg[QB-2:0], pv_reg};
            ov_reg <= v_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prem_reg <= prem_next;
            plo_reg  <= plo_next;
            pl_reg   <= root;
            psd_reg  <= in_nt.side;
            rem_reg  <= rem_next;
            lo_reg   <= lo_next;
            q_reg    <= q_next;
            l_reg[0]  <= pl_reg;
            sd_reg[0] <= psd_reg;
            for (int k = 1; k < QB; k++)
            begin
                l_reg[k]  <= l_reg[k-1];
                sd_reg[k] <= sd_reg[k-1];
            end
            o_reg     <= o_next;
            degen_reg <= sd_reg[QB-1].degen;
            last_reg  <= sd_reg[QB-1].last;
        end
    end

    assign out_valid = ov_reg;
    assign nx        = o_reg[0];
    assign ny        = o_reg[1];
    assign nz        = o_reg[2];
    assign degen     = degen_reg;
    assign last      = last_reg;

endmodule

/* sv/face_normal_unit.sv */
// Unit face normal of a triangle: one item accepted per cycle while the
// output moves. Most of the pipeline depth lies in the 32-stage square root
// and the one-bit-per-stage divider. The whole pipeline holds while a result
// waits under out_stall.
// Reset clears the valid bits only; the pipeline comes up empty.
`timescale 1ns / 1ps

module face_normal_unit import fnu_pkg::*; #(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] p0_x,
    input  logic signed [COORD_BITS-1:0] p0_y,
    input  logic signed [COORD_BITS-1:0] p0_z,
    input  logic signed [COORD_BITS-1:0] p1_x,
    input  logic signed [COORD_BITS-1:0] p1_y,
    input  logic signed [COORD_BITS-1:0] p1_z,
    input  logic signed [COORD_BITS-1:0] p2_x,
    input  logic signed [COORD_BITS-1:0] p2_y,
    input  logic signed [COORD_BITS-1:0] p2_z,
    input  logic                         last_face,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [OUT_BITS-1:0]   normal_x,
    output logic signed [OUT_BITS-1:0]   normal_y,
    output logic signed [OUT_BITS-1:0]   normal_z,
    output logic                         degenerate,
    output logic                         last_out
);

    localparam int EW       = COORD_BITS + 1;
    localparam int EMW      = (EW > 30) ? 30 : EW;
    localparam int MAG_BITS = 2 * EMW + 2;

    logic                         adv;
    logic signed [COORD_BITS-1:0] p [9];
    logic                         f_valid;
    logic [MAG_BITS-1:0]          f_mag [3];
    side_t                        f_side;
    logic                         n_valid;
    logic [SUM_BITS-1:0]          n_sum;
    norm_t                        n_nt;
    logic                         s_valid;
    logic [ROOT_BITS-1:0]         s_root;
    norm_t                        s_nt;
    logic [OUT_BITS-1:0]          nx;
    logic [OUT_BITS-1:0]          ny;
    logic [OUT_BITS-1:0]          nz;

    // Every stage moves together; only a held result stops the pipeline.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    assign p[0] = p0_x;
    assign p[1] = p0_y;
    assign p[2] = p0_z;
    assign p[3] = p1_x;
    assign p[4] = p1_y;
    assign p[5] = p1_z;
    assign p[6] = p2_x;
    assign p[7] = p2_y;
    assign p[8] = p2_z;

    fnu_front #(
        .COORD_BITS (COORD_BITS),
        .MAG_BITS   (MAG_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .p         (p),
        .last_in   (last_face),
        .out_valid (f_valid),
        .mag       (f_mag),
        .side      (f_side)
    );

    fnu_norm #(
        .MAG_BITS (MAG_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .mag       (f_mag),
        .side      (f_side),
        .out_valid (n_valid),
        .sum       (n_sum),
        .nt        (n_nt)
    );

    fnu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n_valid),
        .sum       (n_sum),
        .in_nt     (n_nt),
        .out_valid (s_valid),
        .root      (s_root),
        .out_nt    (s_nt)
    );

    fnu_div #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_valid),
        .root      (s_root),
        .in_nt     (s_nt),
        .out_valid (out_valid),
        .nx        (nx),
        .ny        (ny),
        .nz        (nz),
        .degen     (degenerate),
        .last      (last_out)
    );

    assign normal_x = $signed(nx);
    assign normal_y = $signed(ny);
    assign normal_z = $signed(nz);

endmodule

/* test/tb.sv */
// Self-checking bench for face_normal_unit: random and directed triangles,
// expected unit normals computed in a scoreboard class and compared in order.
// Depends on sv/fnu_pkg.sv and sv/face_normal_unit.sv.
`timescale 1ns / 1ps

module tb;
    import fnu_pkg::*;

    localparam int LATENCY   = 57;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1530;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               degen;
        logic               last;
    } normal_item_t;

    class normal_scoreboard;
        normal_item_t pending[$];
        int           errors;

        function longint unsigned root64(longint unsigned s);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > s)
                b >>= 2;
            while (b != 0)
            begin
                if (s >= res + b)
                begin
                    s -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        // Edges of 16-bit coordinates fit easily, so no edge prescaling occurs.
        function void note_face(logic signed [15:0] v[9], logic lf);
            longint ex[3];
            longint fx[3];
            longint cr[3];
            longint unsigned mg[3];
            longint unsigned top;
            longint unsigned sq;
            longint unsigned len;
            longint unsigned q;
            longint signed_q[3];
            normal_item_t it;
            for (int j = 0; j < 3; j++)
            begin
                ex[j] = longint'(v[3 + j]) - longint'(v[j]);
                fx[j] = longint'(v[6 + j]) - longint'(v[j]);
            end
            cr[0] = ex[1] * fx[2] - ex[2] * fx[1];
            cr[1] = ex[2] * fx[0] - ex[0] * fx[2];
            cr[2] = ex[0] * fx[1] - ex[1] * fx[0];
            it.last = lf;
            if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)
            begin
                it.nx = 0;
                it.ny = 0;
                it.nz = 0;
                it.degen = 1;
            end
            else
            begin
                top = 0;
                for (int j = 0; j < 3; j++)
                begin
                    mg[j] = (cr[j] < 0) ? -cr[j] : cr[j];
                    if (mg[j] > top)
                        top = mg[j];
                end
                while (top >= (64'd1 << 31))
                begin
                    top >>= 1;
                    for (int j = 0; j < 3; j++)
                        mg[j] >>= 1;
                end
                while (top < (64'd1 << 30))
                begin
                    top <<= 1;
                    for (int j = 0; j < 3; j++)
                        mg[j] <<= 1;
                end
                sq = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
                len = root64(sq);
                for (int j = 0; j < 3; j++)
                begin
                    q = ((mg[j] << 14) + (len >> 1)) / len;
                    if (q > 16384)
                        q = 16384;
                    signed_q[j] = (cr[j] < 0) ? -longint'(q) : longint'(q);
                end
                it.nx = signed_q[0][15:0];
                it.ny = signed_q[1][15:0];
                it.nz = signed_q[2][15:0];
                it.degen = 0;
            end
            pending.push_back(it);
        endfunction

        function void check_normal(normal_item_t got);
            normal_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result nx=%0d ny=%0d nz=%0d", $realtime,
                    got.nx, got.ny, got.nz);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.nx !== want.nx)
            begin
                $display("%0t: normal_x expected %0d got %0d", $realtime, want.nx, got.nx);
                errors++;
            end
            if (got.ny !== want.ny)
            begin
                $display("%0t: normal_y expected %0d got %0d", $realtime, want.ny, got.ny);
                errors++;
            end
            if (got.nz !== want.nz)
            begin
                $display("%0t: normal_z expected %0d got %0d", $realtime, want.nz, got.nz);
                errors++;
            end
            if (got.degen !== want.degen)
            begin
                $display("%0t: degenerate expected %0b got %0b", $realtime, want.degen,
                    got.degen);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last_out expected %0b got %0b", $realtime, want.last,
                    got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [15:0] p0_x = 0, p0_y = 0, p0_z = 0;
    logic signed [15:0] p1_x = 0, p1_y = 0, p1_z = 0;
    logic signed [15:0] p2_x = 0, p2_y = 0, p2_z = 0;
    logic last_face = 0;
    logic out_valid;
    logic out_stall = 1;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic degenerate, last_out;

    normal_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  timed_out = 0;
    bit  rx_quiet = 0;

    always #2 clk = ~clk;

    face_normal_unit i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .last_face(last_face), .out_valid(out_valid), .out_stall(out_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .degenerate(degenerate), .last_out(last_out)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sampling happens at the edge; the accept condition uses pre-edge values.
    always @(posedge clk)
    begin
        normal_item_t got;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
                sb.note_face('{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z},
                    last_face);
            if (out_valid && !out_stall)
            begin
                got.nx = normal_x;
                got.ny = normal_y;
                got.nz = normal_z;
                got.degen = degenerate;
                got.last = last_out;
                sb.check_normal(got);
            end
        end
    end

    // Receiver: random stall stretches, with quiet phases of no stalling.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = rx_quiet ? 0 : gap_len();
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_face(logic signed [15:0] v[9], logic lf, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        {p0_x, p0_y, p0_z} <= {v[0], v[1], v[2]};
        {p1_x, p1_y, p1_z} <= {v[3], v[4], v[5]};
        {p2_x, p2_y, p2_z} <= {v[6], v[7], v[8]};
        last_face <= lf;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Advances the clock first, so the item accepted at the previous edge is already noted.
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] rnd_coord(int kind);
        case (kind)
            0: return 16'($urandom());
            1: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] v[9];
        logic signed [15:0] MX, MN;
        int kind, a, b;
        MX = 16'sh7fff;
        MN = 16'sh8000;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: axis-aligned faces, both windings, extremes, degenerate cases.
        send_face('{0, 0, 0, 256, 0, 0, 0, 256, 0}, 0, 0);
        send_face('{0, 0, 0, 0, 256, 0, 256, 0, 0}, 1, 0);
        send_face('{0, 0, 0, 0, 256, 0, 0, 0, 256}, 0, 0);
        send_face('{0, 0, 0, 0, 0, 256, 256, 0, 0}, 0, 0);
        send_face('{MN, MN, MN, MX, MN, MN, MN, MX, MN}, 0, 1);
        send_face('{MX, MX, MX, MN, MX, MX, MX, MN, MX}, 1, 1);
        send_face('{MN, MX, MN, MX, MN, MX, MX, MX, MN}, 0, 0);
        send_face('{MX, MN, MX, MN, MX, MN, MN, MN, MX}, 1, 0);
        send_face('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 0, 0);
        send_face('{0, 0, 0, 1, 1, 1, 1, 2, 3}, 0, 0);
        send_face('{5, 5, 5, 5, 5, 5, 5, 5, 5}, 1, 0);
        send_face('{0, 0, 0, 100, 200, 300, 200, 400, 600}, 0, 0);
        send_face('{1, 2, 3, 1, 2, 3, 9, 8, 7}, 0, 0);
        send_face('{0, 0, 0, 256, 256, 256, MN, MN, MN}, 1, 0);
        send_face('{MN, 0, 0, MX, 0, 0, 0, MX, 0}, 0, 0);
        send_face('{-1, -1, -1, -1, -1, 16'sh7ffe, 16'sh7ffe, -1, -1}, 1, 0);
        drain();

        // Random part; one pause mid-way lets everything come back first.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                drain();
            rx_quiet = (n % 400) < 80;
            kind = $urandom_range(0, 3);
            for (int k = 0; k < 9; k++)
                v[k] = rnd_coord(kind);
            // Some faces are made degenerate on purpose.
            if ($urandom_range(0, 19) == 0)
            begin
                a = int'($urandom_range(0, 8)) - 4;
                for (int k = 0; k < 3; k++)
                    v[6 + k] = v[k] + 16'(a) * (v[3 + k] - v[k]);
                if ($urandom_range(0, 1))
                    for (int k = 0; k < 3; k++)
                        v[3 + k] = v[k];
            end
            b = $urandom_range(0, 1);
            send_face(v, b[0], (n % 300) < 40);
        end
        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

/* sim.f */
sv/fnu_pkg.sv
sv/fnu_front.sv
sv/fnu_norm.sv
sv/fnu_sqrt.sv
sv/fnu_div.sv
sv/face_normal_unit.sv
test/tb.sv
